// ===== hw/rtl/aavr_pkg.sv =====
// Shared types, constants and per-stage datapath functions for the axis-angle
// vector rotation pipeline. No dependencies.
package aavr_pkg;

  localparam int SQRT_STAGES = 16;   // two root bits per stage
  localparam int DIV_STAGES  = 16;   // two quotient bits per stage
  localparam int DIV_STEPS   = 31;
  localparam int NORM_STAGES = 2 + SQRT_STAGES + DIV_STAGES;
  localparam int HORNER_TERMS = 6;
  localparam int SC_STAGES   = 6 + 2 * HORNER_TERMS;
  localparam int ROT_STAGES  = 5;

  localparam logic [15:0] TIME_STEP_RST = 16'd655;
  localparam logic [30:0] ONE_Q30       = 31'h4000_0000;
  localparam logic [34:0] TWO_PI_Q32    = 35'h6_487E_D511;
  localparam logic [35:0] HALF_PI_Q32   = 36'h1_921F_B544;
  localparam logic [35:0] QTR_PI_Q32    = 36'h0_C90F_DAA2;
  localparam logic [35:0] HP2 = HALF_PI_Q32 * 36'd2;
  localparam logic [35:0] HP3 = HALF_PI_Q32 * 36'd3;
  localparam logic [35:0] HP4 = HALF_PI_Q32 * 36'd4;

  // floor(p / n) == (p * RCP) >> SH for p < 2^30, SH = 30 + clog2(n)
  localparam logic [31:0] SRCP0 = 32'(((64'd1 << 37) + 64'd109) / 64'd110);
  localparam logic [31:0] SRCP1 = 32'(((64'd1 << 37) + 64'd71) / 64'd72);
  localparam logic [31:0] SRCP2 = 32'(((64'd1 << 36) + 64'd41) / 64'd42);
  localparam logic [31:0] SRCP3 = 32'(((64'd1 << 35) + 64'd19) / 64'd20);
  localparam logic [31:0] SRCP4 = 32'(((64'd1 << 33) + 64'd5) / 64'd6);
  localparam logic [31:0] CRCP0 = 32'(((64'd1 << 38) + 64'd131) / 64'd132);
  localparam logic [31:0] CRCP1 = 32'(((64'd1 << 37) + 64'd89) / 64'd90);
  localparam logic [31:0] CRCP2 = 32'(((64'd1 << 36) + 64'd55) / 64'd56);
  localparam logic [31:0] CRCP3 = 32'(((64'd1 << 35) + 64'd29) / 64'd30);
  localparam logic [31:0] CRCP4 = 32'(((64'd1 << 34) + 64'd11) / 64'd12);
  localparam logic [31:0] CRCP5 = 32'(((64'd1 << 31) + 64'd1) / 64'd2);

  typedef struct packed {
    logic [2:0][23:0] v;
    logic [2:0][23:0] w;
    logic             zero;
    logic [2:0][47:0] sq;
    logic [63:0]      rad;
    logic [32:0]      rem;
    logic [31:0]      m;
    logic [2:0][31:0] drem;
    logic [2:0][31:0] u;
    logic [39:0]      ang;
    logic [1:0]       q;
    logic             aneg;
    logic [29:0]      b;
    logic [29:0]      x2;
    logic [29:0]      ps;
    logic [29:0]      pc;
    logic [30:0]      ts;
    logic [30:0]      tc;
    logic [31:0]      sn;
    logic [31:0]      cs;
    logic [5:0][31:0] uu;
    logic [2:0][31:0] sk;
    logic [5:0][32:0] sym;
    logic [8:0][34:0] rm;
    logic [8:0][58:0] pr;
    logic [2:0][23:0] res;
  } aavr_item_t;

  function automatic logic [31:0] sin_rcp(int s);
    logic [31:0] r;
    unique case (s)
      0: r = SRCP0;
      1: r = SRCP1;
      2: r = SRCP2;
      3: r = SRCP3;
      default: r = SRCP4;
    endcase
    return r;
  endfunction

  function automatic int sin_sh(int s);
    int r;
    unique case (s)
      0: r = 37;
      1: r = 37;
      2: r = 36;
      3: r = 35;
      default: r = 33;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] cos_rcp(int s);
    logic [31:0] r;
    unique case (s)
      0: r = CRCP0;
      1: r = CRCP1;
      2: r = CRCP2;
      3: r = CRCP3;
      4: r = CRCP4;
      default: r = CRCP5;
    endcase
    return r;
  endfunction

  function automatic int cos_sh(int s);
    int r;
    unique case (s)
      0: r = 38;
      1: r = 37;
      2: r = 36;
      3: r = 35;
      4: r = 34;
      default: r = 31;
    endcase
    return r;
  endfunction

  // ---- magnitude and unit axis ----
  function automatic aavr_item_t f_square(aavr_item_t d);
    aavr_item_t r;
    logic signed [23:0] wi;
    logic signed [47:0] p;
    r = d;
    for (int i = 0; i < 3; i++) begin
      wi = d.w[i];
      p = wi * wi;
      r.sq[i] = p;
    end
    return r;
  endfunction

  function automatic aavr_item_t f_sum(aavr_item_t d);
    aavr_item_t r;
    logic [49:0] s;
    r = d;
    s = 50'(d.sq[0]) + 50'(d.sq[1]) + 50'(d.sq[2]);
    r.zero = (s == 50'd0);
    r.rad  = {s[47:0], 16'h0000};
    r.rem  = '0;
    r.m    = '0;
    return r;
  endfunction

  function automatic aavr_item_t f_sqrt(aavr_item_t d);
    aavr_item_t r;
    logic [34:0] rt, tr, df;
    r = d;
    for (int i = 0; i < 2; i++) begin
      rt = {r.rem, r.rad[63:62]};
      tr = {1'b0, r.m, 2'b01};
      if (rt >= tr) begin
        df = rt - tr;
        r.rem = df[32:0];
        r.m = {r.m[30:0], 1'b1};
      end else begin
        r.rem = rt[32:0];
        r.m = {r.m[30:0], 1'b0};
      end
      r.rad = {r.rad[61:0], 2'b00};
    end
    return r;
  endfunction

  function automatic aavr_item_t f_div(aavr_item_t d, int base, logic first, logic last);
    aavr_item_t r;
    logic [23:0] aw;
    logic [32:0] rs, df;
    r = d;
    for (int i = 0; i < 3; i++) begin
      if (first) begin
        aw = d.w[i][23] ? 24'(~d.w[i] + 24'd1) : d.w[i];
        r.drem[i] = {1'b0, aw, 7'b0};
        r.u[i] = '0;
      end
      for (int s = 0; s < 2; s++) begin
        if (base + s < DIV_STEPS) begin
          rs = {r.drem[i], 1'b0};
          if (rs >= {1'b0, r.m}) begin
            df = rs - {1'b0, r.m};
            r.drem[i] = df[31:0];
            r.u[i] = {r.u[i][30:0], 1'b1};
          end else begin
            r.drem[i] = rs[31:0];
            r.u[i] = {r.u[i][30:0], 1'b0};
          end
        end
      end
      if (last && d.w[i][23]) begin
        r.u[i] = 32'(~r.u[i] + 32'd1);
      end
    end
    return r;
  endfunction

  // ---- angle, sine and cosine ----
  function automatic aavr_item_t f_angle(aavr_item_t d, logic [15:0] tstep);
    aavr_item_t r;
    logic [47:0] p;
    r = d;
    p = 48'(d.m) * 48'(tstep);
    r.ang = p[47:8];
    return r;
  endfunction

  function automatic aavr_item_t f_reduce(aavr_item_t d, logic upper);
    aavr_item_t r;
    logic [39:0] lim;
    int sh;
    r = d;
    for (int j = 0; j < 3; j++) begin
      sh = upper ? 5 - j : 2 - j;
      lim = 40'(TWO_PI_Q32) << sh;
      if (r.ang >= lim) begin
        r.ang = r.ang - lim;
      end
    end
    return r;
  endfunction

  function automatic aavr_item_t f_quad(aavr_item_t d);
    aavr_item_t r;
    logic [35:0] rq, sub;
    logic [2:0] qv;
    logic [36:0] a, mag;
    r = d;
    rq = 36'(d.ang[34:0]) + QTR_PI_Q32;
    qv = 3'(rq >= HALF_PI_Q32) + 3'(rq >= HP2) + 3'(rq >= HP3) + 3'(rq >= HP4);
    unique case (qv)
      3'd1: sub = HALF_PI_Q32;
      3'd2: sub = HP2;
      3'd3: sub = HP3;
      3'd4: sub = HP4;
      default: sub = '0;
    endcase
    a = 37'(d.ang[34:0]) - 37'(sub);
    mag = a[36] ? 37'(~a + 37'd1) : a;
    r.aneg = a[36];
    r.b = mag[31:2];
    r.q = qv[1:0];
    return r;
  endfunction

  function automatic aavr_item_t f_x2(aavr_item_t d);
    aavr_item_t r;
    logic [59:0] p;
    r = d;
    p = 60'(d.b) * 60'(d.b);
    r.x2 = p[59:30];
    r.ts = ONE_Q30;
    r.tc = ONE_Q30;
    return r;
  endfunction

  function automatic aavr_item_t f_hmul(aavr_item_t d, int step);
    aavr_item_t r;
    logic [60:0] pc, ps;
    r = d;
    pc = 61'(d.x2) * 61'(d.tc);
    r.pc = pc[59:30];
    if (step < HORNER_TERMS - 1) begin
      ps = 61'(d.x2) * 61'(d.ts);
    end else begin
      ps = 61'(d.b) * 61'(d.ts);
    end
    r.ps = ps[59:30];
    return r;
  endfunction

  function automatic aavr_item_t f_hdiv(aavr_item_t d, int step);
    aavr_item_t r;
    logic [61:0] pm;
    r = d;
    pm = 62'(d.pc) * 62'(cos_rcp(step));
    pm = pm >> cos_sh(step);
    r.tc = ONE_Q30 - pm[30:0];
    if (step < HORNER_TERMS - 1) begin
      pm = 62'(d.ps) * 62'(sin_rcp(step));
      pm = pm >> sin_sh(step);
      r.ts = ONE_Q30 - pm[30:0];
    end
    return r;
  endfunction

  function automatic aavr_item_t f_qmap(aavr_item_t d);
    aavr_item_t r;
    logic [31:0] sa, ca;
    r = d;
    sa = d.aneg ? 32'(~{2'b00, d.ps} + 32'd1) : {2'b00, d.ps};
    ca = {1'b0, d.tc};
    unique case (d.q)
      2'd0: begin r.sn = sa; r.cs = ca; end
      2'd1: begin r.sn = ca; r.cs = 32'(~sa + 32'd1); end
      2'd2: begin r.sn = 32'(~sa + 32'd1); r.cs = 32'(~ca + 32'd1); end
      default: begin r.sn = 32'(~ca + 32'd1); r.cs = sa; end
    endcase
    return r;
  endfunction

  // ---- rotation matrix and product ----
  function automatic logic [31:0] mulq30(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[61:30];
  endfunction

  function automatic aavr_item_t f_uprod(aavr_item_t d);
    aavr_item_t r;
    r = d;
    r.uu[0] = mulq30(d.u[0], d.u[0]);
    r.uu[1] = mulq30(d.u[1], d.u[1]);
    r.uu[2] = mulq30(d.u[2], d.u[2]);
    r.uu[3] = mulq30(d.u[0], d.u[1]);
    r.uu[4] = mulq30(d.u[0], d.u[2]);
    r.uu[5] = mulq30(d.u[1], d.u[2]);
    for (int k = 0; k < 3; k++) begin
      r.sk[k] = mulq30(d.sn, d.u[k]);
    end
    return r;
  endfunction

  function automatic aavr_item_t f_sym(aavr_item_t d);
    aavr_item_t r;
    logic signed [32:0] omc;
    logic signed [31:0] uv;
    logic signed [64:0] p;
    r = d;
    omc = 33'sd1073741824 - $signed({d.cs[31], d.cs});
    for (int k = 0; k < 6; k++) begin
      uv = d.uu[k];
      p = uv * omc;
      r.sym[k] = p[62:30];
    end
    return r;
  endfunction

  function automatic aavr_item_t f_mat(aavr_item_t d);
    aavr_item_t r;
    logic [34:0] c, s0, s1, s2, s3, s4, s5, k0, k1, k2;
    r = d;
    c  = {{3{d.cs[31]}}, d.cs};
    s0 = {{2{d.sym[0][32]}}, d.sym[0]};
    s1 = {{2{d.sym[1][32]}}, d.sym[1]};
    s2 = {{2{d.sym[2][32]}}, d.sym[2]};
    s3 = {{2{d.sym[3][32]}}, d.sym[3]};
    s4 = {{2{d.sym[4][32]}}, d.sym[4]};
    s5 = {{2{d.sym[5][32]}}, d.sym[5]};
    k0 = {{3{d.sk[0][31]}}, d.sk[0]};
    k1 = {{3{d.sk[1][31]}}, d.sk[1]};
    k2 = {{3{d.sk[2][31]}}, d.sk[2]};
    r.rm[0] = c + s0;
    r.rm[1] = s3 - k2;
    r.rm[2] = s4 + k1;
    r.rm[3] = s3 + k2;
    r.rm[4] = c + s1;
    r.rm[5] = s5 - k0;
    r.rm[6] = s4 - k1;
    r.rm[7] = s5 + k0;
    r.rm[8] = c + s2;
    return r;
  endfunction

  function automatic aavr_item_t f_mulv(aavr_item_t d);
    aavr_item_t r;
    logic signed [34:0] a;
    logic signed [23:0] b;
    logic signed [58:0] p;
    r = d;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        a = d.rm[3*i + j];
        b = d.v[j];
        p = a * b;
        r.pr[3*i + j] = p;
      end
    end
    return r;
  endfunction

  function automatic aavr_item_t f_out(aavr_item_t d);
    aavr_item_t r;
    logic signed [58:0] p0, p1, p2;
    logic signed [60:0] acc;
    logic signed [30:0] y;
    r = d;
    for (int i = 0; i < 3; i++) begin
      p0 = d.pr[3*i];
      p1 = d.pr[3*i + 1];
      p2 = d.pr[3*i + 2];
      acc = p0 + p1 + p2 + 61'sd536870912;
      y = acc[60:30];
      if (d.zero) begin
        r.res[i] = d.v[i];
      end else if (y > 31'sd8388607) begin
        r.res[i] = 24'h7F_FFFF;
      end else if (y < -31'sd8388608) begin
        r.res[i] = 24'h80_0000;
      end else begin
        r.res[i] = y[23:0];
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/aavr_stage.sv =====
// One elastic pipeline register: valid travels with the data, ready flows back.
// Depends on nothing; the payload type is a parameter.
module aavr_stage #(
  parameter type T = logic
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  T     in_data,
  output logic out_valid,
  input  logic out_ready,
  output T     out_data
);

  logic valid_r;
  T     data_r;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= in_data;
    end
  end

endmodule

// ===== hw/rtl/aavr_norm.sv =====
// Rate magnitude (squares, sum, digit-by-digit square root) and unit axis
// (restoring dividers). Depends on aavr_pkg and aavr_stage.
module aavr_norm
  import aavr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  aavr_item_t in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output aavr_item_t out_item
);

  localparam int N = NORM_STAGES;

  aavr_item_t q [N+1];
  logic [N:0] v, r;

  assign q[0]      = in_item;
  assign v[0]      = in_valid;
  assign in_ready  = r[0];
  assign out_item  = q[N];
  assign out_valid = v[N];
  assign r[N]      = out_ready;

  for (genvar g = 0; g < N; g++) begin : g_st
    aavr_item_t d;
    if (g == 0) begin : g_sq
      assign d = f_square(q[g]);
    end else if (g == 1) begin : g_sum
      assign d = f_sum(q[g]);
    end else if (g < 2 + SQRT_STAGES) begin : g_sqrt
      assign d = f_sqrt(q[g]);
    end else begin : g_div
      assign d = f_div(q[g], 2 * (g - 2 - SQRT_STAGES), 1'(g == 2 + SQRT_STAGES),
                       1'(g == N - 1));
    end
    aavr_stage #(.T(aavr_item_t)) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v[g]),
      .in_ready  (r[g]),
      .in_data   (d),
      .out_valid (v[g+1]),
      .out_ready (r[g+1]),
      .out_data  (q[g+1])
    );
  end

endmodule

// ===== hw/rtl/aavr_sincos.sv =====
// Rotation angle, range reduction, Horner series for sine and cosine and the
// quadrant fold. Depends on aavr_pkg and aavr_stage.
module aavr_sincos
  import aavr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] time_step,
  input  logic        in_valid,
  output logic        in_ready,
  input  aavr_item_t  in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output aavr_item_t  out_item
);

  localparam int N = SC_STAGES;

  aavr_item_t q [N+1];
  logic [N:0] v, r;

  assign q[0]      = in_item;
  assign v[0]      = in_valid;
  assign in_ready  = r[0];
  assign out_item  = q[N];
  assign out_valid = v[N];
  assign r[N]      = out_ready;

  for (genvar g = 0; g < N; g++) begin : g_st
    aavr_item_t d;
    if (g == 0) begin : g_ang
      assign d = f_angle(q[g], time_step);
    end else if (g == 1) begin : g_red_hi
      assign d = f_reduce(q[g], 1'b1);
    end else if (g == 2) begin : g_red_lo
      assign d = f_reduce(q[g], 1'b0);
    end else if (g == 3) begin : g_quad
      assign d = f_quad(q[g]);
    end else if (g == 4) begin : g_x2
      assign d = f_x2(q[g]);
    end else if (g == N - 1) begin : g_qmap
      assign d = f_qmap(q[g]);
    end else if (((g - 5) % 2) == 0) begin : g_hmul
      assign d = f_hmul(q[g], (g - 5) / 2);
    end else begin : g_hdiv
      assign d = f_hdiv(q[g], (g - 5) / 2);
    end
    aavr_stage #(.T(aavr_item_t)) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v[g]),
      .in_ready  (r[g]),
      .in_data   (d),
      .out_valid (v[g+1]),
      .out_ready (r[g+1]),
      .out_data  (q[g+1])
    );
  end

endmodule

// ===== hw/rtl/aavr_rotate.sv =====
// Rodrigues matrix build, matrix-vector product, rounding and saturation.
// Depends on aavr_pkg and aavr_stage.
module aavr_rotate
  import aavr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  aavr_item_t in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output aavr_item_t out_item
);

  localparam int N = ROT_STAGES;

  aavr_item_t q [N+1];
  logic [N:0] v, r;

  assign q[0]      = in_item;
  assign v[0]      = in_valid;
  assign in_ready  = r[0];
  assign out_item  = q[N];
  assign out_valid = v[N];
  assign r[N]      = out_ready;

  for (genvar g = 0; g < N; g++) begin : g_st
    aavr_item_t d;
    if (g == 0) begin : g_up
      assign d = f_uprod(q[g]);
    end else if (g == 1) begin : g_sym
      assign d = f_sym(q[g]);
    end else if (g == 2) begin : g_mat
      assign d = f_mat(q[g]);
    end else if (g == 3) begin : g_mulv
      assign d = f_mulv(q[g]);
    end else begin : g_out
      assign d = f_out(q[g]);
    end
    aavr_stage #(.T(aavr_item_t)) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v[g]),
      .in_ready  (r[g]),
      .in_data   (d),
      .out_valid (v[g+1]),
      .out_ready (r[g+1]),
      .out_data  (q[g+1])
    );
  end

endmodule

// ===== hw/rtl/axis_angle_vector_rotation.sv =====
// Top level of the axis-angle vector rotation pipeline.
// Depends on aavr_pkg, aavr_stage, aavr_norm, aavr_sincos and aavr_rotate.
//
// Rotates a signed Q8.16 vector about the axis of an angular-rate vector by
// the angle |rate| * time_step (Rodrigues form), one transfer in and one
// transfer out per item. The pipeline takes a new item every cycle unless a
// stalled output has backed it up, and holds 57 items in flight: 34 stages
// for the magnitude (2 square-root bits a stage) and the unit axis (2 quotient
// bits a stage on three dividers), 18 for angle reduction and the sine/cosine
// Horner series (multiply and reciprocal multiply in alternate stages), 5 for
// the matrix and the product. Each stage holds its own valid bit, so bubbles
// collapse and a stalled output lets the stages behind it keep filling. A zero
// rate passes the vector through unchanged; results are rounded to nearest and
// saturated to 24 bits. time_step resets to 655 (about 10 ms) and is meant to
// be written only while the pipeline is empty.
module axis_angle_vector_rotation
  import aavr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_time_step,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] in_vec_x,
  input  logic [23:0] in_vec_y,
  input  logic [23:0] in_vec_z,
  input  logic [23:0] in_rate_x,
  input  logic [23:0] in_rate_y,
  input  logic [23:0] in_rate_z,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_x,
  output logic [23:0] out_y,
  output logic [23:0] out_z
);

  logic [15:0] time_step_r;
  aavr_item_t  in_item, n_item, s_item, r_item;
  logic        n_valid, n_ready, s_valid, s_ready;

  // config transfer is always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= TIME_STEP_RST;
    end else if (cfg_valid) begin
      time_step_r <= cfg_time_step;
    end
  end

  // item enters with only its input fields set
  always_comb begin
    in_item = '0;
    in_item.v[0] = in_vec_x;
    in_item.v[1] = in_vec_y;
    in_item.v[2] = in_vec_z;
    in_item.w[0] = in_rate_x;
    in_item.w[1] = in_rate_y;
    in_item.w[2] = in_rate_z;
  end

  aavr_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (n_valid),
    .out_ready (n_ready),
    .out_item  (n_item)
  );

  aavr_sincos u_sincos (
    .clk       (clk),
    .rst_n     (rst_n),
    .time_step (time_step_r),
    .in_valid  (n_valid),
    .in_ready  (n_ready),
    .in_item   (n_item),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_item  (s_item)
  );

  aavr_rotate u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .in_item   (s_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (r_item)
  );

  assign out_x = r_item.res[0];
  assign out_y = r_item.res[1];
  assign out_z = r_item.res[2];

endmodule

// ===== hw/rtl/aavr_checker.sv =====
// Port-level checks for the rotation pipeline, bound to the top level.
// Depends on axis_angle_vector_rotation.
module aavr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_x,
  input logic [23:0] out_y,
  input logic [23:0] out_z
);

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a drained output never blocks the input side
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is being taken");

  // an offered input stays offered until its transfer
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input valid dropped before transfer");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_z))
    else $error("stalled result changed or dropped");

endmodule

bind axis_angle_vector_rotation aavr_checker u_aavr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_x     (out_x),
  .out_y     (out_y),
  .out_z     (out_z)
);
